>>> rtl/gbm_pkg.sv
package gbm_pkg;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_SMALL = 3'd1;
  localparam logic [2:0] CMD_LARGE = 3'd2;
  localparam logic [2:0] CMD_PIXEL = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [7:0] SMALL_FIRST = 8'h20;
  localparam logic [7:0] SMALL_LAST  = 8'h7A;
  localparam logic [7:0] SMALL_SUBST = 8'h3F;

  // request handed from the command decoder to the row engine
  typedef struct packed {
    logic [2:0]        cmd;
    logic [39:0]       small_cols;
    logic [127:0]      large_cols;
    logic              large_ok;
    logic signed [9:0] x;
    logic signed [7:0] y;
    logic [6:0]        rd_row;
    logic [3:0]        rd_grp;
  } job_t;

  // five column bytes (0..4) of the small font; the engine draws them at cell columns 1..5, column 0 blank
  function automatic logic [39:0] small_glyph(input logic [7:0] code);
    logic [7:0] k;
    logic [39:0] g;
    k = code;
    if (code < SMALL_FIRST || code > SMALL_LAST) k = SMALL_SUBST;
    unique case (k)
      8'h20: g = 40'h0000000000; 8'h21: g = 40'h00002F0000; 8'h22: g = 40'h0007000700;
      8'h23: g = 40'h147F147F14; 8'h24: g = 40'h242A7F2A12; 8'h25: g = 40'h2313086462;
      8'h26: g = 40'h3649552250; 8'h27: g = 40'h0005030000; 8'h28: g = 40'h001C224100;
      8'h29: g = 40'h0041221C00; 8'h2A: g = 40'h14083E0814; 8'h2B: g = 40'h08083E0808;
      8'h2C: g = 40'h0000A06000; 8'h2D: g = 40'h0808080808; 8'h2E: g = 40'h0060600000;
      8'h2F: g = 40'h2010080402; 8'h30: g = 40'h3E5149453E; 8'h31: g = 40'h00427F4000;
      8'h32: g = 40'h4261514946; 8'h33: g = 40'h2141454B31; 8'h34: g = 40'h1814127F10;
      8'h35: g = 40'h2745454539; 8'h36: g = 40'h3C4A494930; 8'h37: g = 40'h0171090503;
      8'h38: g = 40'h3649494936; 8'h39: g = 40'h064949291E; 8'h3A: g = 40'h0036360000;
      8'h3B: g = 40'h0056360000; 8'h3C: g = 40'h0814224100; 8'h3D: g = 40'h1414141414;
      8'h3E: g = 40'h0041221408; 8'h3F: g = 40'h0201510906; 8'h40: g = 40'h324959513E;
      8'h41: g = 40'h7C1211127C; 8'h42: g = 40'h7F49494936; 8'h43: g = 40'h3E41414122;
      8'h44: g = 40'h7F4141221C; 8'h45: g = 40'h7F49494941; 8'h46: g = 40'h7F09090901;
      8'h47: g = 40'h3E4149497A; 8'h48: g = 40'h7F0808087F; 8'h49: g = 40'h00417F4100;
      8'h4A: g = 40'h2040413F01; 8'h4B: g = 40'h7F08142241; 8'h4C: g = 40'h7F40404040;
      8'h4D: g = 40'h7F020C027F; 8'h4E: g = 40'h7F0408107F; 8'h4F: g = 40'h3E4141413E;
      8'h50: g = 40'h7F09090906; 8'h51: g = 40'h3E4151215E; 8'h52: g = 40'h7F09192946;
      8'h53: g = 40'h4649494931; 8'h54: g = 40'h01017F0101; 8'h55: g = 40'h3F4040403F;
      8'h56: g = 40'h1F2040201F; 8'h57: g = 40'h3F4038403F; 8'h58: g = 40'h6314081463;
      8'h59: g = 40'h0708700807; 8'h5A: g = 40'h6151494543; 8'h5B: g = 40'h007F414100;
      8'h5C: g = 40'h552A552A55; 8'h5D: g = 40'h0041417F00; 8'h5E: g = 40'h0402010204;
      8'h5F: g = 40'h4040404040; 8'h60: g = 40'h0001020400; 8'h61: g = 40'h2054545478;
      8'h62: g = 40'h7F48444438; 8'h63: g = 40'h3844444420; 8'h64: g = 40'h384444487F;
      8'h65: g = 40'h3854545418; 8'h66: g = 40'h087E090102; 8'h67: g = 40'h18A4A4A47C;
      8'h68: g = 40'h7F08040478; 8'h69: g = 40'h00447D4000; 8'h6A: g = 40'h4080847D00;
      8'h6B: g = 40'h7F10284400; 8'h6C: g = 40'h00417F4000; 8'h6D: g = 40'h7C04180478;
      8'h6E: g = 40'h7C08040478; 8'h6F: g = 40'h3844444438; 8'h70: g = 40'hFC24242418;
      8'h71: g = 40'h18242418FC; 8'h72: g = 40'h7C08040408; 8'h73: g = 40'h4854545420;
      8'h74: g = 40'h043F444020; 8'h75: g = 40'h3C4040207C; 8'h76: g = 40'h1C2040201C;
      8'h77: g = 40'h3C4030403C; 8'h78: g = 40'h4428102844; 8'h79: g = 40'h1CA0A0A07C;
      8'h7A: g = 40'h4464544C44;
      default: g = 40'h0201510906;
    endcase
    // reorder so column c sits at bits [8c+7:8c]
    return {g[7:0], g[15:8], g[23:16], g[31:24], g[39:32]};
  endfunction

  // sixteen bytes, byte i at [8i+7:8i]; bytes 0..7 top half
  function automatic logic [127:0] large_glyph(input logic [7:0] code);
    logic [127:0] g;
    unique case (code)
      8'h30: g = {8'h00,8'h0F,8'h10,8'h20,8'h20,8'h10,8'h0F,8'h00,
                  8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00};
      8'h31: g = {8'h00,8'h00,8'h20,8'h20,8'h3F,8'h20,8'h20,8'h00,
                  8'h00,8'h00,8'h00,8'h00,8'hF8,8'h10,8'h10,8'h00};
      8'h32: g = {8'h00,8'h30,8'h21,8'h22,8'h24,8'h28,8'h30,8'h00,
                  8'h00,8'h70,8'h88,8'h08,8'h08,8'h08,8'h70,8'h00};
      8'h33: g = {8'h00,8'h0E,8'h11,8'h20,8'h20,8'h20,8'h18,8'h00,
                  8'h00,8'h30,8'h48,8'h88,8'h88,8'h08,8'h30,8'h00};
      8'h34: g = {8'h00,8'h24,8'h3F,8'h24,8'h24,8'h04,8'h07,8'h00,
                  8'h00,8'h00,8'hF8,8'h10,8'h20,8'hC0,8'h00,8'h00};
      8'h35: g = {8'h00,8'h0E,8'h11,8'h20,8'h20,8'h21,8'h19,8'h00,
                  8'h00,8'h08,8'h08,8'h88,8'h88,8'h08,8'hF8,8'h00};
      8'h36: g = {8'h00,8'h0E,8'h11,8'h20,8'h20,8'h11,8'h0F,8'h00,
                  8'h00,8'h00,8'h18,8'h88,8'h88,8'h10,8'hE0,8'h00};
      8'h37: g = {8'h00,8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,
                  8'h00,8'h08,8'h38,8'hC8,8'h08,8'h08,8'h38,8'h00};
      8'h38: g = {8'h00,8'h1C,8'h22,8'h21,8'h21,8'h22,8'h1C,8'h00,
                  8'h00,8'h70,8'h88,8'h08,8'h08,8'h88,8'h70,8'h00};
      8'h39: g = {8'h00,8'h0F,8'h11,8'h22,8'h22,8'h31,8'h00,8'h00,
                  8'h00,8'hE0,8'h10,8'h08,8'h08,8'h10,8'hE0,8'h00};
      8'h3A: g = {8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h00,
                  8'h00,8'h00,8'h00,8'hC0,8'hC0,8'h00,8'h00,8'h00};
      8'h2E: g = {8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,8'h00,8'h00,
                  8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
      8'h2D: g = {8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h00,
                  8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00,8'h00};
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic large_known(input logic [7:0] code);
    return (code >= 8'h30 && code <= 8'h3A) || code == 8'h2E || code == 8'h2D;
  endfunction

endpackage

>>> rtl/gbm_row_engine.sv
module gbm_row_engine #(
  parameter int W = 128,
  parameter int H = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  gbm_pkg::job_t job,
  input  logic          bit_order_msb,
  output logic          busy,
  output logic          rd_done,
  output logic [7:0]    rd_byte
);
  import gbm_pkg::*;

  localparam int AW = $clog2(H);
  localparam int XW = $clog2(W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;

  logic [W-1:0] mem [H];
  logic [W-1:0] q_r;
  logic [2:0]   st_r, st_nxt;
  job_t         job_r;
  logic [4:0]   step_r, step_nxt;
  logic [AW:0]  clr_r, clr_nxt;
  logic         init_r, init_nxt;

  // row touched by the current step and whether it is on screen
  logic signed [9:0] row_s;
  logic              row_ok;
  logic [AW-1:0]     row_a;
  logic [W-1:0]      mask;
  logic [4:0]        last_step;

  always_comb begin
    row_s  = 10'(job_r.y) + 10'(step_r);
    row_ok = (row_s >= 0) && (row_s < 10'(H));
    row_a  = row_s[AW-1:0];
    last_step = (job_r.cmd == CMD_LARGE) ? 5'd15 :
                (job_r.cmd == CMD_PIXEL) ? 5'd0 : 5'd7;
  end

  // one row of the glyph: bit r of column c lies at x+c
  always_comb begin
    logic signed [11:0] xc;
    logic [2:0] r;
    logic       half;
    r    = step_r[2:0];
    half = step_r[3];
    mask = '0;
    for (int c = 0; c < 8; c++) begin
      xc = 12'(job_r.x) + 12'(c);
      if (xc >= 0 && xc < 12'(W)) begin
        unique case (job_r.cmd)
          CMD_SMALL:
            if (c >= 1 && c <= 5) mask[xc[XW-2:0]] = job_r.small_cols[8*(c-1) + r];
          CMD_LARGE:
            mask[xc[XW-2:0]] = job_r.large_cols[64*half + 8*c + r];
          CMD_PIXEL:
            if (c == 0) mask[xc[XW-2:0]] = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    clr_nxt  = clr_r;
    init_nxt = init_r;
    unique case (st_r)
      S_IDLE:
        if (!init_r) begin
          st_nxt  = S_CLEAR;
          clr_nxt = '0;
        end else if (start) begin
          step_nxt = '0;
          unique case (job.cmd)
            CMD_CLEAR: begin st_nxt = S_CLEAR; clr_nxt = '0; end
            CMD_SMALL, CMD_PIXEL: st_nxt = S_READ;
            CMD_LARGE: st_nxt = job.large_ok ? S_READ : S_IDLE;
            CMD_READ: st_nxt = S_FETCH;
            default: st_nxt = S_IDLE;
          endcase
        end
      S_READ: st_nxt = S_WRITE;
      S_WRITE:
        if (step_r == last_step) st_nxt = S_IDLE;
        else begin
          step_nxt = step_r + 5'd1;
          st_nxt   = S_READ;
        end
      S_CLEAR:
        if (clr_r == (AW+1)'(H-1)) begin
          st_nxt   = S_IDLE;
          init_nxt = 1'b1;
        end else clr_nxt = clr_r + 1'b1;
      S_FETCH: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // state and job registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      step_r <= '0;
      clr_r  <= '0;
      init_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      clr_r  <= clr_nxt;
      init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && start) job_r <= job;
  end

  // row memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR) mem[clr_r[AW-1:0]] <= '0;
    else if (st_r == S_WRITE && row_ok) mem[row_a] <= q_r | mask;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_READ) q_r <= mem[row_a];
    else if (st_r == S_IDLE && start) q_r <= mem[job.rd_row[AW-1:0]];
  end

  // read-back packing
  always_comb begin
    logic [11:0] px;
    rd_byte = '0;
    for (int b = 0; b < 8; b++) begin
      px = {job_r.rd_grp, 3'(b)} + 12'd0;
      if (px < 12'(W) && int'(job_r.rd_row) < H) begin
        if (bit_order_msb) rd_byte[7-b] = q_r[px[XW-2:0]];
        else rd_byte[b] = q_r[px[XW-2:0]];
      end
    end
  end

  assign busy    = (st_r != S_IDLE) || !init_r;
  assign rd_done = (st_r == S_FETCH);

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |=> !rd_done) else $error("read result held twice");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WRITE) |-> $past(st_r) == S_READ) else $error("write without read");
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR && st_nxt == S_IDLE) |-> clr_r == (AW+1)'(H-1))
    else $error("clear pass cut short");
`endif
endmodule

>>> rtl/glyph_blit_mono_framebuffer_core.sv
// Monochrome frame store with 6x8 and 8x16 font ROMs. Rows live in a
// one-port-read synchronous memory; each glyph row is read, ORed and written
// back in a read state and a write state. An idle engine accepts a
// transaction and is then busy for eight rows (small glyph), sixteen (large
// glyph), one (pixel), one row fetch (read) or all SCREEN_HEIGHT rows (clear);
// reserved commands and large glyphs with no font entry leave it idle. The
// read byte passes from the row register through the fetch state into the
// result register, and input stalls until that result is taken. After reset
// a clearing pass over all SCREEN_HEIGHT rows runs before the first
// transaction is accepted. One transaction is in work at a time.
module glyph_blit_mono_framebuffer_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [7:0]        in_char_code,
  input  logic signed [9:0] in_x_pos,
  input  logic signed [7:0] in_y_pos,
  input  logic [5:0]        in_read_row,
  input  logic [3:0]        in_read_column_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_packed_byte
);
  import gbm_pkg::*;

  logic       bit_order_r;
  logic       busy, rd_done, start;
  logic [7:0] rd_byte;
  job_t       job;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) bit_order_r <= 1'b0;
    else if (cfg_we) bit_order_r <= cfg_wdata;
  end

  // decode the transaction into a job
  always_comb begin
    job.cmd        = in_command;
    job.small_cols = small_glyph(in_char_code);
    job.large_cols = large_glyph(in_char_code);
    job.large_ok   = large_known(in_char_code);
    job.x          = (in_command == CMD_SMALL) ? in_x_pos + 10'sd0 : in_x_pos;
    job.y          = in_y_pos;
    job.rd_row     = {1'b0, in_read_row};
    job.rd_grp     = in_read_column_byte;
  end

  assign in_stall = busy || out_valid;
  assign start    = in_valid && !in_stall;

  gbm_row_engine #(.W(SCREEN_WIDTH), .H(SCREEN_HEIGHT)) u_eng (
    .clk, .rst_n, .start, .job, .bit_order_msb(bit_order_r),
    .busy, .rd_done, .rd_byte
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (rd_done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rd_done) out_packed_byte <= rd_byte;
  end

`ifndef SYNTHESIS
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !start) else $error("accept while result pending");
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> !out_valid) else $error("result overwritten");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall) else $error("accept while busy");
`endif
endmodule
